// ===== hw/rtl/assert_macros.svh =====
// ============================================================================
// assert_macros.svh
// Assertion shorthands shared by the PEC15 appender modules.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define PFA_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pfa assertion failed");

// Check that an antecedent implies a consequent in the same cycle
`define PFA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfa assertion failed");

`endif

// ===== hw/rtl/pfa_pkg.sv =====
// ============================================================================
// pfa_pkg
// Types, constants and the CRC-15 byte update shared by the PEC15 appender.
// ============================================================================
`default_nettype none

package pfa_pkg;

    // CRC-15 polynomial and seed
    localparam logic [14:0] PEC_POLY = 15'h4599;
    localparam logic [14:0] PEC_SEED = 15'd16;

    // Queue between the front and back parts
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified byte waiting for the back part
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        frame_end;
        logic [15:0] pec;
    } pfa_entry_t;

    // Push side of the queue
    typedef struct packed {
        logic       valid;
        pfa_entry_t entry;
    } pfa_push_t;

    // Output phase of the back part
    typedef enum logic [1:0] {
        PH_DATA,
        PH_PEC_HI,
        PH_PEC_LO
    } pfa_phase_t;

    // Advance the remainder over one byte, MSB first
    function automatic logic [14:0] crc_byte(input logic [14:0] rem, input logic [7:0] din);
        logic [14:0] r;
        logic        fb;
        r = rem;
        for (int b = 7; b >= 0; b--)
        begin
            fb = r[14] ^ din[b];
            r  = {r[13:0], 1'b0};
            if (fb)
            begin
                r = r ^ PEC_POLY;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pfa_front.sv =====
// ============================================================================
// pfa_front
// Accepts frame bytes, runs the CRC-15 remainder and pushes each byte with
// its frame PEC into the queue.
// ============================================================================
`default_nettype none

module pfa_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [7:0]        data_byte,
    input  wire logic              frame_end,
    input  wire logic              q_full,
    output pfa_pkg::pfa_push_t     push
);

    logic [14:0] crc_reg;
    logic [14:0] crc_next;
    logic [14:0] crc_upd;
    logic        accept;

    // Take a byte whenever the queue has room
    assign accept = in_valid && !q_full;
    assign crc_upd = pfa_pkg::crc_byte(crc_reg, data_byte);

    // Build the queue entry; the PEC field only matters on a frame end
    always_comb
    begin
        push.valid           = accept;
        push.entry.data_byte = data_byte;
        push.entry.frame_end = frame_end;
        push.entry.pec       = {crc_upd, 1'b0};
        crc_next             = crc_reg;
        if (accept)
        begin
            crc_next = frame_end ? pfa_pkg::PEC_SEED : crc_upd;
        end
    end

    // Hold the running remainder; return to the seed after each frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= pfa_pkg::PEC_SEED;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pfa_queue.sv =====
// ============================================================================
// pfa_queue
// Short first-in first-out queue of classified bytes between front and back.
// ============================================================================
`default_nettype none
`include "assert_macros.svh"

module pfa_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pfa_pkg::pfa_push_t  push,
    input  wire logic                pop,
    output logic                     full,
    output logic                     q_valid,
    output pfa_pkg::pfa_entry_t      q_entry
);

    pfa_pkg::pfa_entry_t                  mem [pfa_pkg::QDEPTH];
    logic [pfa_pkg::QPTR_W-1:0]           wr_ptr_reg;
    logic [pfa_pkg::QPTR_W-1:0]           wr_ptr_next;
    logic [pfa_pkg::QPTR_W-1:0]           rd_ptr_reg;
    logic [pfa_pkg::QPTR_W-1:0]           rd_ptr_next;
    logic [pfa_pkg::QCNT_W-1:0]           count_reg;
    logic [pfa_pkg::QCNT_W-1:0]           count_next;
    logic                                 do_pop;

    assign full    = (count_reg == pfa_pkg::QCNT_W'(pfa_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = mem[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == pfa_pkg::QPTR_W'(pfa_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == pfa_pkg::QPTR_W'(pfa_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push.valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push.valid)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

    `PFA_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= pfa_pkg::QCNT_W'(pfa_pkg::QDEPTH))
    `PFA_ASSERT_IMPLIES(a_no_push_full, clk, rst_n, push.valid, !full)
    `PFA_ASSERT_IMPLIES(a_ptr_gap, clk, rst_n, count_reg == '0, wr_ptr_reg == rd_ptr_reg)

endmodule

`default_nettype wire

// ===== hw/rtl/pfa_back.sv =====
// ============================================================================
// pfa_back
// Pops queued bytes, sends each data byte and, at a frame end, the two
// PEC bytes through a registered output stage.
// ============================================================================
`default_nettype none
`include "assert_macros.svh"

module pfa_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire pfa_pkg::pfa_entry_t  q_entry,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [7:0]                out_byte,
    output logic                      is_pec,
    output logic                      out_last
);

    pfa_pkg::pfa_phase_t phase_reg;
    pfa_pkg::pfa_phase_t phase_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [7:0]          out_byte_reg;
    logic [7:0]          out_byte_next;
    logic                is_pec_reg;
    logic                is_pec_next;
    logic                out_last_reg;
    logic                out_last_next;
    logic [15:0]         pec_reg;
    logic [15:0]         pec_next;
    logic                load;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign is_pec    = is_pec_reg;
    assign out_last  = out_last_reg;

    // Refill the output register when it is empty or its transfer completes
    assign load = !out_valid_reg || !out_stall;

    // Next phase and next output
    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        is_pec_next    = is_pec_reg;
        out_last_next  = out_last_reg;
        pec_next       = pec_reg;
        pop            = 1'b0;
        if (load)
        begin
            unique case (phase_reg)
                pfa_pkg::PH_DATA:
                begin
                    out_valid_next = q_valid;
                    out_byte_next  = q_entry.data_byte;
                    is_pec_next    = 1'b0;
                    out_last_next  = 1'b0;
                    if (q_valid)
                    begin
                        pop = 1'b1;
                        if (q_entry.frame_end)
                        begin
                            pec_next   = q_entry.pec;
                            phase_next = pfa_pkg::PH_PEC_HI;
                        end
                    end
                end
                pfa_pkg::PH_PEC_HI:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = pec_reg[15:8];
                    is_pec_next    = 1'b1;
                    out_last_next  = 1'b0;
                    phase_next     = pfa_pkg::PH_PEC_LO;
                end
                pfa_pkg::PH_PEC_LO:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = pec_reg[7:0];
                    is_pec_next    = 1'b1;
                    out_last_next  = 1'b1;
                    phase_next     = pfa_pkg::PH_DATA;
                end
                default:
                begin
                    out_valid_next = 1'b0;
                    phase_next     = pfa_pkg::PH_DATA;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pfa_pkg::PH_DATA;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        is_pec_reg   <= is_pec_next;
        out_last_reg <= out_last_next;
        pec_reg      <= pec_next;
    end

    `PFA_ASSERT_IMPLIES(a_last_is_pec, clk, rst_n, out_valid_reg && out_last_reg, is_pec_reg)
    `PFA_ASSERT_IMPLIES(a_lo_after_hi, clk, rst_n, phase_reg == pfa_pkg::PH_PEC_LO,
        $past(phase_reg) == pfa_pkg::PH_PEC_HI || $past(phase_reg) == pfa_pkg::PH_PEC_LO)
    `PFA_ASSERT_IMPLIES(a_no_pop_in_pec, clk, rst_n, phase_reg != pfa_pkg::PH_DATA, !pop)

endmodule

`default_nettype wire

// ===== hw/rtl/pec15_frame_appender_unit.sv =====
// ============================================================================
// pec15_frame_appender_unit
// Byte stream pass-through that appends a CRC-15 PEC after each frame.
// ============================================================================
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid / in_stall  | data_byte, frame_end
//  out     | output    | out_valid / out_stall| out_byte, is_pec, out_last
//
//  One byte is accepted per cycle while the four-entry queue has room.
//  Each data byte passes through the queue and then the single output
//  register of the back part; a frame end adds the two PEC bytes, sent
//  from that output register after the last data byte of the frame.
//  Reset returns the remainder to the seed and empties the queue.
//  in_stall rises only when the queue is full; a stall on the output holds
//  the output register and fills the queue.
//
`default_nettype none

module pec15_frame_appender_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        frame_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             is_pec,
    output logic             out_last
);

    pfa_pkg::pfa_push_t  push;
    pfa_pkg::pfa_entry_t q_entry;
    logic                q_full;
    logic                q_valid;
    logic                pop;

    assign in_stall = q_full;

    pfa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .q_full    (q_full),
        .push      (push)
    );

    pfa_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop     (pop),
        .full    (q_full),
        .q_valid (q_valid),
        .q_entry (q_entry)
    );

    pfa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .is_pec    (is_pec),
        .out_last  (out_last)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pec15_frame_appender_unit: drives framed bytes with
// random bursts and output stalls, and checks every echoed byte and both PEC
// bytes of each frame against a bit-exact CRC-15 predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam logic [14:0] CRC_POLY    = 15'h4599;
    localparam logic [14:0] CRC_SEED    = 15'd16;
    localparam int          RANDOM_ITEMS = 400;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          HOLD_CYCLES  = 60;
    localparam int          HOLD_AFTER   = 300;
    localparam int          NUM_ROWS     = 20;

    // One output transfer as it should appear on the result channel
    typedef struct packed {
        logic [7:0] value;
        logic       pec_flag;
        logic       last_flag;
    } out_beat_t;

    // One row of the directed table; echo is typed in where known outright
    typedef struct packed {
        logic [7:0] data;
        logic       ends;
        logic       typed;
        logic [7:0] echo;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] data_byte;
    logic       frame_end;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       is_pec;
    logic       out_last;

    out_beat_t   pending_beats[$];
    logic [14:0] crc_rem;
    int          mismatch_count = 0;
    int          beats_seen     = 0;
    int          cycle_count    = 0;

    // Single-byte frames at the extremes, an unterminated lead-in byte,
    // longer frames of all-ones and alternating patterns
    stim_row_t directed_rows [0:NUM_ROWS-1] = '{
        '{8'h00, 1'b0, 1'b1, 8'h00},
        '{8'h00, 1'b1, 1'b0, 8'h00},
        '{8'hFF, 1'b1, 1'b0, 8'h00},
        '{8'h00, 1'b1, 1'b0, 8'h00},
        '{8'h80, 1'b1, 1'b0, 8'h00},
        '{8'h01, 1'b1, 1'b0, 8'h00},
        '{8'h7F, 1'b1, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 1'b1, 8'hFF},
        '{8'hFF, 1'b0, 1'b1, 8'hFF},
        '{8'hFF, 1'b0, 1'b1, 8'hFF},
        '{8'hFF, 1'b1, 1'b0, 8'h00},
        '{8'h55, 1'b0, 1'b1, 8'h55},
        '{8'hAA, 1'b0, 1'b1, 8'hAA},
        '{8'h0F, 1'b1, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b1, 8'h00},
        '{8'h01, 1'b1, 1'b0, 8'h00},
        '{8'h12, 1'b0, 1'b1, 8'h12},
        '{8'h34, 1'b0, 1'b1, 8'h34},
        '{8'h56, 1'b0, 1'b1, 8'h56},
        '{8'h78, 1'b1, 1'b0, 8'h00}
    };

    pec15_frame_appender_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .is_pec    (is_pec),
        .out_last  (out_last)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Fold one byte into the remainder, MSB first
    function automatic logic [14:0] pec15_update(input logic [14:0] rem,
                                                 input logic [7:0]  value);
        logic [14:0] acc;
        acc = rem ^ {value, 7'b0};
        for (int k = 0; k < 8; k++)
        begin
            if (acc[14])
                acc = {acc[13:0], 1'b0} ^ CRC_POLY;
            else
                acc = {acc[13:0], 1'b0};
        end
        return acc;
    endfunction

    // Queue the results of one accepted byte and advance the remainder
    task automatic predict_frame_bytes(input logic [7:0] value, input logic ends,
                                       input logic typed, input logic [7:0] echo);
        logic [15:0] pec_word;
        crc_rem = pec15_update(crc_rem, value);
        pending_beats.push_back('{typed ? echo : value, 1'b0, 1'b0});
        if (ends)
        begin
            pec_word = {crc_rem, 1'b0};
            pending_beats.push_back('{pec_word[15:8], 1'b1, 1'b0});
            pending_beats.push_back('{pec_word[7:0], 1'b1, 1'b1});
            crc_rem = CRC_SEED;
        end
    endtask

    // Offer one byte from a falling edge, hold it until the transfer, and
    // return at the next falling edge
    task automatic offer_byte(input logic [7:0] value, input logic ends,
                              input logic typed, input logic [7:0] echo);
        in_valid  <= 1'b1;
        data_byte <= value;
        frame_end <= ends;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_frame_bytes(value, ends, typed, echo);
        @(negedge clk);
    endtask

    // Sender: directed table, then random frames in bursts
    initial
    begin
        int burst_left;
        int gap;
        int sent;
        int frame_len;
        logic [7:0] value;

        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        data_byte      <= 8'h00;
        frame_end      <= 1'b0;
        crc_rem        = CRC_SEED;
        burst_left     = 0;
        sent           = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table back to back
        for (int r = 0; r < NUM_ROWS; r++)
            offer_byte(directed_rows[r].data, directed_rows[r].ends,
                       directed_rows[r].typed, directed_rows[r].echo);

        // Pause until the directed results have drained
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(negedge clk);
        @(negedge clk);

        while (sent < RANDOM_ITEMS)
        begin
            // Mostly short frames, now and then a long one
            if ($urandom_range(0, 9) == 0)
                frame_len = $urandom_range(9, 24);
            else
                frame_len = $urandom_range(1, 6);
            for (int i = 0; i < frame_len; i++)
            begin
                case ($urandom_range(0, 11))
                    0: value = 8'h00;
                    1: value = 8'hFF;
                    2: value = 8'h80;
                    3: value = 8'h01;
                    default: value = 8'($urandom_range(0, 255));
                endcase
                offer_byte(value, (i == frame_len - 1), 1'b0, 8'h00);
                sent++;

                // Idle between bursts; some bursts run without a gap
                if (burst_left <= 0)
                begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    if (gap > 0)
                    begin
                        in_valid <= 1'b0;
                        repeat (gap - 1) @(negedge clk);
                        @(negedge clk);
                    end
                    burst_left = $urandom_range(1, 30);
                end
                else
                begin
                    burst_left--;
                end
            end

            // Hold back once midway until every result is out
            if (sent >= RANDOM_ITEMS / 2 && sent - frame_len < RANDOM_ITEMS / 2)
            begin
                in_valid <= 1'b0;
                while (pending_beats.size() != 0)
                    @(negedge clk);
                @(negedge clk);
            end
        end

        // Drain and settle
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Receiver: stall in patterns that change at random, with
    // one long hold-off to fill the block up
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        bit hold_done;

        out_stall <= 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (!hold_done && beats_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left <= 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 9) < 3);
                    2: out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // Compare each output transfer with the oldest expectation
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_seen <= beats_seen + 1;
            if (pending_beats.size() == 0)
            begin
                $display("%0t: unexpected output transfer, out_byte %02h is_pec %0b out_last %0b",
                         $time, out_byte, is_pec, out_last);
                mismatch_count++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (out_byte !== want.value)
                begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.value, out_byte);
                    mismatch_count++;
                end
                if (is_pec !== want.pec_flag)
                begin
                    $display("%0t: is_pec expected %0b actual %0b",
                             $time, want.pec_flag, is_pec);
                    mismatch_count++;
                end
                if (out_last !== want.last_flag)
                begin
                    $display("%0t: out_last expected %0b actual %0b",
                             $time, want.last_flag, out_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, pending_beats.size());
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
